/* sv/ghct_pkg.sv */
// types, constants and the virtual button map of the gamepad hold counter tracker
package ghct_pkg;

  localparam int CountW   = 14;
  localparam int AxisW    = 16;
  localparam int LimitW   = 13;
  localparam int ThreshW  = 15;
  localparam int CfgDataW = 15;
  localparam int NumVirtual = 10;
  localparam int VirtIdxW   = 4;

  localparam logic [LimitW-1:0]  HoldLimitReset = 13'd5000;
  localparam logic [ThreshW-1:0] AxisThreshReset = 15'd8192;

  typedef enum logic [1:0] {
    CMD_BUTTON = 2'd0,
    CMD_AXIS   = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic {
    CFG_HOLD_LIMIT     = 1'b0,
    CFG_AXIS_THRESHOLD = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [4:0]         code;
    logic               pressed;
    logic [2:0]         axis_index;
    logic signed [15:0] axis_value;
  } item_t;

  typedef struct packed {
    logic signed [13:0] hold_count;
    logic               is_down;
    logic               just_pressed;
    logic               just_released;
  } result_t;

  typedef enum logic [1:0] {
    RD_NONE      = 2'd0,
    RD_CODE      = 2'd1,
    RD_WALK_AGE  = 2'd2,
    RD_WALK_VIRT = 2'd3
  } rd_e;

  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_BUTTON = 2'd1,
    WR_AGE    = 2'd2,
    WR_VIRT   = 2'd3
  } wr_e;

  typedef struct packed {
    logic latch;
    logic axis_wr;
    logic walk_clr;
    logic out_load;
    rd_e  rd;
    wr_e  wr;
  } dp_cmd_t;

  typedef struct packed {
    logic age_last;
    logic virt_last;
  } dp_status_t;

  typedef struct packed {
    logic [4:0] code;
    logic [2:0] axis;
    logic       positive;
  } virt_t;

  // virtual buttons: triggers, then left stick and right stick directions
  function automatic virt_t virt_entry(input logic [VirtIdxW-1:0] idx);
    virt_t e;
    case (idx)
      4'd0:    e = '{code: 5'd15, axis: 3'd4, positive: 1'b1};
      4'd1:    e = '{code: 5'd16, axis: 3'd5, positive: 1'b1};
      4'd2:    e = '{code: 5'd17, axis: 3'd0, positive: 1'b0};
      4'd3:    e = '{code: 5'd18, axis: 3'd0, positive: 1'b1};
      4'd4:    e = '{code: 5'd19, axis: 3'd1, positive: 1'b1};
      4'd5:    e = '{code: 5'd20, axis: 3'd1, positive: 1'b0};
      4'd6:    e = '{code: 5'd21, axis: 3'd2, positive: 1'b0};
      4'd7:    e = '{code: 5'd22, axis: 3'd2, positive: 1'b1};
      4'd8:    e = '{code: 5'd23, axis: 3'd3, positive: 1'b1};
      4'd9:    e = '{code: 5'd24, axis: 3'd3, positive: 1'b0};
      default: e = '{code: 5'd31, axis: 3'd7, positive: 1'b0};
    endcase
    return e;
  endfunction

endpackage

/* sv/gamepad_hold_counter_tracker.sv */
// gamepad hold counter tracker: top level
// Usage: drive item_i and raise start; the item is taken at a clock edge where start is
// high and busy is low. busy stays high while the item is worked on. Every item returns
// one result beat on result_o, marked by result_valid_o for exactly one cycle; the
// receiver must take it then, there is no back-pressure.
// A query reads its counter and loads the result; an axis or button event first updates
// its axis register or counter, and a frame tick first walks the counter store: one counter
// aged per cycle, then one virtual button per cycle, with the read of the next entry
// overlapping the write-back of the current one. busy drops in the cycle the result is
// shown, so a new item may be accepted there; one item is in flight at a time.
// Configuration: cfg_we_i with cfg_idx_i 0 writes the hold limit, 1 the axis threshold;
// written only while busy is low, a rule on the user that the block itself does not enforce.
// Reset: counters and axis values read as zero, hold limit 5000, threshold 8192; no
// clearing pass is needed.
module gamepad_hold_counter_tracker #(
  parameter int NUM_CODES            = 25,
  parameter int NUM_AXES             = 6,
  parameter int NUM_PHYSICAL_BUTTONS = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  ghct_pkg::item_t   item_i,
  output logic              busy,
  output ghct_pkg::result_t result_o,
  output logic              result_valid_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [14:0]       cfg_wdata_i
);
  import ghct_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  ghct_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .cmd_i    (item_i.cmd),
    .status_i (dp_status),
    .dp_cmd_o (dp_cmd),
    .busy_o   (busy)
  );

  ghct_datapath #(
    .NUM_CODES            (NUM_CODES),
    .NUM_AXES             (NUM_AXES),
    .NUM_PHYSICAL_BUTTONS (NUM_PHYSICAL_BUTTONS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .dp_cmd_i       (dp_cmd),
    .status_o       (dp_status),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

/* sv/ghct_ctrl.sv */
// sequencer for the gamepad hold counter tracker
module ghct_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  ghct_pkg::cmd_e       cmd_i,
  input  ghct_pkg::dp_status_t status_i,
  output ghct_pkg::dp_cmd_t    dp_cmd_o,
  output logic                 busy_o
);
  import ghct_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_BTN_RD   = 10'b00_0000_0010,
    S_BTN_WR   = 10'b00_0000_0100,
    S_AXIS_WR  = 10'b00_0000_1000,
    S_AGE_RD   = 10'b00_0001_0000,
    S_AGE      = 10'b00_0010_0000,
    S_VIRT_RD  = 10'b00_0100_0000,
    S_VIRT     = 10'b00_1000_0000,
    S_QUERY_RD = 10'b01_0000_0000,
    S_OUT      = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    dp_cmd_o = '{latch: 1'b0, axis_wr: 1'b0, walk_clr: 1'b0, out_load: 1'b0,
                 rd: RD_NONE, wr: WR_NONE};
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          dp_cmd_o.latch = 1'b1;
          case (cmd_i)
            CMD_BUTTON: state_d = S_BTN_RD;
            CMD_AXIS:   state_d = S_AXIS_WR;
            CMD_TICK:   state_d = S_AGE_RD;
            CMD_QUERY:  state_d = S_QUERY_RD;
            default:    state_d = S_QUERY_RD;
          endcase
        end
      end
      S_BTN_RD: begin
        dp_cmd_o.rd = RD_CODE;
        state_d     = S_BTN_WR;
      end
      S_BTN_WR: begin
        dp_cmd_o.wr = WR_BUTTON;
        state_d     = S_QUERY_RD;
      end
      S_AXIS_WR: begin
        dp_cmd_o.axis_wr = 1'b1;
        state_d          = S_QUERY_RD;
      end
      S_AGE_RD: begin
        dp_cmd_o.rd = RD_WALK_AGE;
        state_d     = S_AGE;
      end
      // read of the next counter overlaps the write-back of this one
      S_AGE: begin
        dp_cmd_o.wr = WR_AGE;
        if (status_i.age_last) begin
          dp_cmd_o.walk_clr = 1'b1;
          state_d           = S_VIRT_RD;
        end else begin
          dp_cmd_o.rd = RD_WALK_AGE;
        end
      end
      S_VIRT_RD: begin
        dp_cmd_o.rd = RD_WALK_VIRT;
        state_d     = S_VIRT;
      end
      S_VIRT: begin
        dp_cmd_o.wr = WR_VIRT;
        if (status_i.virt_last) begin
          state_d = S_QUERY_RD;
        end else begin
          dp_cmd_o.rd = RD_WALK_VIRT;
        end
      end
      S_QUERY_RD: begin
        dp_cmd_o.rd = RD_CODE;
        state_d     = S_OUT;
      end
      S_OUT: begin
        dp_cmd_o.out_load = 1'b1;
        state_d           = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

/* sv/ghct_datapath.sv */
// counter memory, axis registers, configuration and result registers
module ghct_datapath #(
  parameter int NUM_CODES            = 25,
  parameter int NUM_AXES             = 6,
  parameter int NUM_PHYSICAL_BUTTONS = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ghct_pkg::item_t      item_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [14:0]          cfg_wdata_i,
  input  ghct_pkg::dp_cmd_t    dp_cmd_i,
  output ghct_pkg::dp_status_t status_o,
  output ghct_pkg::result_t    result_o,
  output logic                 result_valid_o
);
  import ghct_pkg::*;

  localparam int AW = (NUM_CODES > 1) ? $clog2(NUM_CODES) : 1;
  localparam int XW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int CW = $clog2(NUM_CODES + 1);
  localparam int WW = (CW > VirtIdxW) ? CW : VirtIdxW;

  function automatic logic signed [CountW-1:0] count_up(
    input logic signed [CountW-1:0] c,
    input logic [LimitW-1:0]        lim
  );
    logic signed [CountW:0] n;
    logic signed [CountW:0] l;
    n = {c[CountW-1], c} + 15'sd1;
    l = $signed({2'b00, lim});
    if (n < 15'sd1) n = 15'sd1;
    if (n > l) n = l;
    return n[CountW-1:0];
  endfunction

  function automatic logic signed [CountW-1:0] count_down(
    input logic signed [CountW-1:0] c,
    input logic [LimitW-1:0]        lim
  );
    logic signed [CountW:0] n;
    logic signed [CountW:0] l;
    n = {c[CountW-1], c} - 15'sd1;
    l = -$signed({2'b00, lim});
    if (n > -15'sd1) n = -15'sd1;
    if (n < l) n = l;
    return n[CountW-1:0];
  endfunction

  item_t                    item_q;
  logic [LimitW-1:0]        limit_q;
  logic [ThreshW-1:0]       thresh_q;
  logic signed [AxisW-1:0]  axis_q [NUM_AXES];
  logic signed [CountW-1:0] cnt_mem_q [NUM_CODES];
  logic [NUM_CODES-1:0]     cnt_vld_q;
  logic signed [CountW-1:0] rd_data_q;
  logic                     rd_vld_q;
  logic [WW-1:0]            ridx_q, widx_q;
  result_t                  result_q;
  logic                     result_valid_q;

  logic [LimitW-1:0]        lim;
  logic signed [CountW-1:0] rd_cnt;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [CountW-1:0] wr_data;
  virt_t                    virt_rd, virt_wr;
  logic signed [AxisW-1:0]  virt_axis;
  logic signed [AxisW:0]    vx, thx;
  logic                     ax_down;
  logic                     code_ok;
  logic signed [CountW-1:0] res_cnt;

  assign lim     = (limit_q == '0) ? LimitW'(1) : limit_q;
  assign code_ok = (32'(item_q.code) < NUM_CODES);
  assign virt_rd = virt_entry(VirtIdxW'(ridx_q));
  assign virt_wr = virt_entry(VirtIdxW'(widx_q));
  assign rd_cnt  = rd_vld_q ? rd_data_q : '0;

  always_comb begin
    virt_axis = '0;
    if (32'(virt_wr.axis) < NUM_AXES) begin
      virt_axis = axis_q[XW'(virt_wr.axis)];
    end
  end

  assign vx      = {virt_axis[AxisW-1], virt_axis};
  assign thx     = $signed({2'b00, thresh_q});
  assign ax_down = virt_wr.positive ? (vx >= thx) : (vx <= -thx);

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    case (dp_cmd_i.rd)
      RD_CODE:      rd_addr = AW'(item_q.code);
      RD_WALK_AGE:  rd_addr = AW'(ridx_q);
      RD_WALK_VIRT: rd_addr = AW'(virt_rd.code);
      default:      rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (dp_cmd_i.wr)
      WR_BUTTON: begin
        wr_addr = AW'(item_q.code);
        wr_en   = code_ok && (32'(item_q.code) < NUM_PHYSICAL_BUTTONS);
        wr_data = item_q.pressed ? count_up(rd_cnt, lim) : -14'sd1;
      end
      WR_AGE: begin
        wr_addr = AW'(widx_q);
        wr_en   = 1'b1;
        wr_data = (rd_cnt > 14'sd0) ? count_up(rd_cnt, lim) : count_down(rd_cnt, lim);
      end
      WR_VIRT: begin
        wr_addr = AW'(virt_wr.code);
        if (32'(virt_wr.code) < NUM_CODES) begin
          if (rd_cnt > 14'sd0 && !ax_down) begin
            wr_en   = 1'b1;
            wr_data = -14'sd1;
          end else if (rd_cnt < 14'sd0 && ax_down) begin
            wr_en   = 1'b1;
            wr_data = 14'sd1;
          end
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // counter store, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cnt_mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= cnt_mem_q[rd_addr];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        cnt_vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= cnt_vld_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= HoldLimitReset;
      thresh_q <= AxisThreshReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_HOLD_LIMIT:     limit_q  <= LimitW'(cfg_wdata_i);
        CFG_AXIS_THRESHOLD: thresh_q <= ThreshW'(cfg_wdata_i);
        default:            limit_q  <= limit_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        axis_q[i] <= '0;
      end
    end else if (dp_cmd_i.axis_wr && (32'(item_q.axis_index) < NUM_AXES)) begin
      axis_q[XW'(item_q.axis_index)] <= item_q.axis_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.latch) begin
      item_q <= item_i;
    end
  end

  // walk pointers: widx trails ridx by one read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ridx_q <= '0;
      widx_q <= '0;
    end else if (dp_cmd_i.latch || dp_cmd_i.walk_clr) begin
      ridx_q <= '0;
      widx_q <= '0;
    end else if (dp_cmd_i.rd == RD_WALK_AGE || dp_cmd_i.rd == RD_WALK_VIRT) begin
      ridx_q <= ridx_q + WW'(1);
      widx_q <= ridx_q;
    end
  end

  assign status_o.age_last  = (widx_q == WW'(NUM_CODES - 1));
  assign status_o.virt_last = (widx_q == WW'(NumVirtual - 1));

  assign res_cnt = code_ok ? rd_cnt : '0;

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.out_load) begin
      result_q.hold_count    <= res_cnt;
      result_q.is_down       <= (res_cnt > 14'sd0);
      result_q.just_pressed  <= (res_cnt == 14'sd1);
      result_q.just_released <= (res_cnt == -14'sd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= dp_cmd_i.out_load;
    end
  end

  assign result_o       = result_q;
  assign result_valid_o = result_valid_q;

endmodule

/* sv/ghct_checker.sv */
// port-level checks for the gamepad hold counter tracker, bound to the top level
module ghct_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input ghct_pkg::item_t   item_i,
  input logic              busy,
  input ghct_pkg::result_t result_o,
  input logic              result_valid_o,
  input logic              cfg_we_i,
  input logic              cfg_idx_i,
  input logic [14:0]       cfg_wdata_i
);
  import ghct_pkg::*;

  // accepted beat keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // result beat only once the item is done
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (!busy && $past(busy)))
    else $error("result beat while still busy");

  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  a_flags_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((result_o.is_down == (result_o.hold_count > 14'sd0)) &&
                        (result_o.just_pressed == (result_o.hold_count == 14'sd1)) &&
                        (result_o.just_released == (result_o.hold_count == -14'sd1))))
    else $error("result flags disagree with hold count");

endmodule

bind gamepad_hold_counter_tracker ghct_checker u_ghct_checker (.*);

/* dv/gamepad_hold_counter_tracker_test.sv */
// self-checking testbench of the gamepad hold counter tracker with a built-in counter predictor
module gamepad_hold_counter_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ghct_pkg::*;

  localparam int NumCodes    = 25;
  localparam int NumAxes     = 6;
  localparam int NumPhysical = 15;
  localparam int IdleLimit   = 2000;
  localparam int PhaseItems  = 305;

  // virtual buttons in map order: code is 15 plus the position
  localparam int VirtAxis [NumVirtual] = '{4, 5, 0, 0, 1, 1, 2, 2, 3, 3};
  localparam bit VirtPos  [NumVirtual] = '{1, 1, 0, 1, 1, 0, 0, 1, 1, 0};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  item_t       stim_item = '0;
  logic        busy;
  result_t     result;
  logic        result_valid;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = 1'b0;
  logic [14:0] cfg_wdata = '0;

  item_t   pending_q [$];
  result_t expected_q [$];

  int          hold_ctr [NumCodes];
  int          axis_val [NumAxes];
  int unsigned hold_limit = HoldLimitReset;
  int unsigned axis_thresh = AxisThreshReset;

  logic item_taken = 1'b0;
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   burst_left = 1;
  int   gap_left = 0;

  gamepad_hold_counter_tracker #(
    .NUM_CODES           (NumCodes),
    .NUM_AXES            (NumAxes),
    .NUM_PHYSICAL_BUTTONS(NumPhysical)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .item_i        (stim_item),
    .busy          (busy),
    .result_o      (result),
    .result_valid_o(result_valid),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  always #6ns clk_i = ~clk_i;

  function automatic int step_up(int c, int lim);
    int n;
    n = c + 1;
    if (n < 1) n = 1;
    if (n > lim) n = lim;
    return n;
  endfunction

  // applies one item to the counter state and returns the beat it should answer with
  function automatic result_t predict_beat(item_t it);
    result_t r;
    int      c;
    int      lim;
    int      th;
    int      v;
    bit      down;
    lim = (hold_limit == 0) ? 1 : int'(hold_limit);
    th  = int'(axis_thresh);
    case (it.cmd)
      CMD_BUTTON: begin
        if (it.code < NumPhysical && it.code < NumCodes)
          hold_ctr[it.code] = it.pressed ? step_up(hold_ctr[it.code], lim) : -1;
      end
      CMD_AXIS: begin
        if (it.axis_index < NumAxes) axis_val[it.axis_index] = $signed(it.axis_value);
      end
      CMD_TICK: begin
        for (int i = 0; i < NumCodes; i++) begin
          if (hold_ctr[i] > 0) begin
            hold_ctr[i] = step_up(hold_ctr[i], lim);
          end else begin
            c = hold_ctr[i] - 1;
            if (c > -1) c = -1;
            if (c < -lim) c = -lim;
            hold_ctr[i] = c;
          end
        end
        // virtual buttons follow their axis after ageing
        for (int k = 0; k < NumVirtual; k++) begin
          if (15 + k < NumCodes) begin
            v    = (VirtAxis[k] < NumAxes) ? axis_val[VirtAxis[k]] : 0;
            down = VirtPos[k] ? (v >= th) : (v <= -th);
            if (hold_ctr[15 + k] > 0 && !down) hold_ctr[15 + k] = -1;
            else if (hold_ctr[15 + k] < 0 && down) hold_ctr[15 + k] = 1;
          end
        end
      end
      default: ;
    endcase
    c = (it.code < NumCodes) ? hold_ctr[it.code] : 0;
    r.hold_count    = c[13:0];
    r.is_down       = c > 0;
    r.just_pressed  = c == 1;
    r.just_released = c == -1;
    return r;
  endfunction

  function automatic item_t make_item(cmd_e cmd, int code, bit pressed, int axis, int value);
    item_t it;
    it.cmd        = cmd;
    it.code       = code[4:0];
    it.pressed    = pressed;
    it.axis_index = axis[2:0];
    it.axis_value = value[15:0];
    return it;
  endfunction

  // mostly meaningful beats; unused fields carry random noise
  function automatic item_t rand_item();
    item_t it;
    int    pick;
    int    th;
    int    v;
    th = int'(axis_thresh);
    it = item_t'({$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 35) it.cmd = CMD_BUTTON;
    else if (pick < 55) it.cmd = CMD_AXIS;
    else if (pick < 85) it.cmd = CMD_TICK;
    else it.cmd = CMD_QUERY;
    if ($urandom_range(0, 19) == 0) it.code = 5'($urandom_range(NumCodes, 31));
    else if (it.cmd == CMD_BUTTON && $urandom_range(0, 4) != 0)
      it.code = 5'($urandom_range(0, NumPhysical - 1));
    else it.code = 5'($urandom_range(0, NumCodes - 1));
    it.pressed = $urandom_range(0, 99) < 65;
    if ($urandom_range(0, 15) == 0) it.axis_index = 3'($urandom_range(NumAxes, 7));
    else it.axis_index = 3'($urandom_range(0, NumAxes - 1));
    case ($urandom_range(0, 4))
      0: v = th + int'($urandom_range(0, 4)) - 2;
      1: v = -th + int'($urandom_range(0, 4)) - 2;
      2: v = int'($urandom_range(0, 65535)) - 32768;
      3: begin
        case ($urandom_range(0, 3))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          default: v = -1;
        endcase
      end
      default: v = int'($urandom_range(0, 200)) - 100;
    endcase
    it.axis_value = v[15:0];
    return it;
  endfunction

  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value[14:0];
    if (idx == CFG_HOLD_LIMIT) hold_limit = value & 32'h1fff;
    else axis_thresh = value & 32'h7fff;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // returns once every item is taken and every beat has come back
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || start || busy || expected_q.size() != 0);
  endtask

  task automatic report(string why, result_t want, result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: want count %0d down %b jp %b jr %b, got count %0d down %b jp %b jr %b",
               why, want.hold_count, want.is_down, want.just_pressed, want.just_released,
               got.hold_count, got.is_down, got.just_pressed, got.just_released);
  endtask

  // sender: bursts of items with random gaps between them
  always @(negedge clk_i) begin
    if (rst_ni && (!start || item_taken)) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (pending_q.size() != 0) begin
        stim_item <= pending_q.pop_front();
        start <= 1'b1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          burst_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 60 : 8);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      item_taken <= start && !busy;
      if (result_valid) begin
        if (expected_q.size() == 0) report("unexpected beat", '0, result);
        else if (result.hold_count !== expected_q[0].hold_count ||
                 result.is_down !== expected_q[0].is_down ||
                 result.just_pressed !== expected_q[0].just_pressed ||
                 result.just_released !== expected_q[0].just_released)
          report("wrong beat", expected_q.pop_front(), result);
        else void'(expected_q.pop_front());
      end
      if (start && !busy) expected_q.push_back(predict_beat(stim_item));
      if ((start && !busy) || result_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned limits [6];
    int unsigned thresholds [6];
    limits     = '{3, 0, 1, 8191, 20, 2};
    thresholds = '{8192, 0, 32767, 100, 16000, 1};
    foreach (hold_ctr[i]) hold_ctr[i] = 0;
    foreach (axis_val[i]) axis_val[i] = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed beats under the reset settings
    pending_q.push_back(make_item(CMD_QUERY, 0, 0, 0, 0));
    pending_q.push_back(make_item(CMD_QUERY, 31, 1, 7, -1));
    pending_q.push_back(make_item(CMD_BUTTON, 0, 1, 0, 0));
    pending_q.push_back(make_item(CMD_BUTTON, 0, 1, 0, 0));
    pending_q.push_back(make_item(CMD_BUTTON, 14, 1, 0, 0));
    pending_q.push_back(make_item(CMD_BUTTON, 3, 0, 0, 0));
    pending_q.push_back(make_item(CMD_BUTTON, 15, 1, 0, 0));
    pending_q.push_back(make_item(CMD_BUTTON, 31, 1, 0, 0));
    pending_q.push_back(make_item(CMD_BUTTON, 25, 0, 0, 0));
    pending_q.push_back(make_item(CMD_AXIS, 15, 0, 4, 8192));
    pending_q.push_back(make_item(CMD_AXIS, 17, 0, 0, -32768));
    pending_q.push_back(make_item(CMD_AXIS, 19, 0, 1, 32767));
    pending_q.push_back(make_item(CMD_AXIS, 21, 0, 2, -8192));
    pending_q.push_back(make_item(CMD_AXIS, 23, 0, 3, 8191));
    pending_q.push_back(make_item(CMD_AXIS, 16, 0, 5, -1));
    pending_q.push_back(make_item(CMD_AXIS, 0, 0, 6, 32767));
    pending_q.push_back(make_item(CMD_AXIS, 0, 0, 7, -32768));
    pending_q.push_back(make_item(CMD_TICK, 0, 0, 0, 0));
    pending_q.push_back(make_item(CMD_QUERY, 15, 0, 0, 0));
    pending_q.push_back(make_item(CMD_QUERY, 17, 0, 0, 0));
    pending_q.push_back(make_item(CMD_TICK, 24, 0, 0, 0));
    pending_q.push_back(make_item(CMD_QUERY, 3, 0, 0, 0));
    pending_q.push_back(make_item(CMD_BUTTON, 0, 1, 0, 0));
    pending_q.push_back(make_item(CMD_QUERY, 19, 0, 0, 0));
    pending_q.push_back(make_item(CMD_QUERY, 24, 0, 0, 0));
    wait_idle();

    // each phase starts from an idle block with fresh register settings
    foreach (limits[p]) begin
      write_reg(CFG_HOLD_LIMIT, limits[p]);
      write_reg(CFG_AXIS_THRESHOLD, thresholds[p]);
      repeat (PhaseItems) pending_q.push_back(rand_item());
      wait_idle();
    end

    repeat (45) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $display("%0d beats never arrived", expected_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
